// ===== rtl/bmar_pkg.sv =====
// ----------------------------------------------------------------------------
// bmar_pkg
// Shared types and constants for the bus memory with address register.
// ----------------------------------------------------------------------------
`default_nettype none

package bmar_pkg;

  localparam int RAM_DEPTH = 32768;
  localparam int ROM_DEPTH = 32768;
  localparam int RAM_AW    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
  localparam int ROM_AW    = (ROM_DEPTH > 1) ? $clog2(ROM_DEPTH) : 1;

  localparam int ADDR_W    = 16;
  localparam int BYTE_W    = 8;
  localparam int ID_W      = 4;
  localparam int LIM_W     = ADDR_W + 1;
  localparam int CFG_IDX_W = 2;

  localparam logic [ID_W-1:0] DEV_MEMORY  = 4'h7;
  localparam logic [ID_W-1:0] DEV_ADDRESS = 4'hF;

  localparam logic [ADDR_W-1:0] LOW_BYTE_MASK  = 16'h00FF;
  localparam logic [ADDR_W-1:0] HIGH_BYTE_MASK = 16'hFF00;

  localparam logic [ADDR_W-1:0] RAM_BASE_RST   = 16'h0000;
  localparam logic [ADDR_W-1:0] RAM_LENGTH_RST = 16'h8000;
  localparam logic [ADDR_W-1:0] ROM_BASE_RST   = 16'h8000;
  localparam logic [ADDR_W-1:0] ROM_LENGTH_RST = 16'h8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RAM_BASE   = 2'd0,
    CFG_RAM_LENGTH = 2'd1,
    CFG_ROM_BASE   = 2'd2,
    CFG_ROM_LENGTH = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic              cmd;
    logic              data_enable_n;
    logic              address_enable_n;
    logic [ID_W-1:0]   get_id;
    logic [ID_W-1:0]   put_id;
    logic [BYTE_W-1:0] addr_bus_byte;
    logic [BYTE_W-1:0] data_bus_byte;
    logic              high_byte_sel;
    logic [ADDR_W-1:0] preload_address;
  } in_item_t;

  typedef struct packed {
    logic              drive_valid;
    logic [BYTE_W-1:0] drive_byte;
    logic              fault;
  } out_item_t;

  // memory requests of one transaction, decoded by the control unit
  typedef struct packed {
    logic              ram_en;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_addr;
    logic              rom_en;
    logic              rom_we;
    logic [ROM_AW-1:0] rom_addr;
    logic [BYTE_W-1:0] wdata;
    logic              rd_ram;
    logic              rd_rom;
    logic              fault;
  } mem_req_t;

endpackage

`default_nettype wire

// ===== rtl/bmar_ram.sv =====
// ----------------------------------------------------------------------------
// bmar_ram
// Single-port synchronous RAM, read-first, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bmar_ram #(
  parameter int DEPTH = 32768,
  parameter int WIDTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents when the same entry is written
  always_ff @(posedge clk) begin
    if (en) begin
      rdata <= mem[addr];
      if (we) begin
        mem[addr] <= wdata;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bmar_ctrl.sv =====
// ----------------------------------------------------------------------------
// bmar_ctrl
// Window registers, address register and decode of one bus transaction into
// RAM and ROM requests.
// ----------------------------------------------------------------------------
`default_nettype none

module bmar_ctrl (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [bmar_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [bmar_pkg::ADDR_W-1:0]         cfg_data,
  input  wire bmar_pkg::in_item_t                  item,
  input  wire logic                                accept,
  output bmar_pkg::mem_req_t                       req
);

  logic [bmar_pkg::ADDR_W-1:0] ram_base;
  logic [bmar_pkg::ADDR_W-1:0] ram_length;
  logic [bmar_pkg::ADDR_W-1:0] rom_base;
  logic [bmar_pkg::ADDR_W-1:0] rom_length;
  logic [bmar_pkg::ADDR_W-1:0] address_reg;
  logic [bmar_pkg::ADDR_W-1:0] address_reg_next;

  logic [bmar_pkg::LIM_W-1:0]  ram_lim;
  logic [bmar_pkg::LIM_W-1:0]  rom_lim;
  logic [bmar_pkg::ADDR_W-1:0] ram_off_a;
  logic [bmar_pkg::ADDR_W-1:0] rom_off_a;
  logic [bmar_pkg::ADDR_W-1:0] ram_off_p;
  logic [bmar_pkg::ADDR_W-1:0] rom_off_p;
  logic                        ram_hit_a;
  logic                        rom_hit_a;
  logic                        ram_hit_p;
  logic                        rom_hit_p;
  logic                        de;
  logic                        ae;
  logic                        rd;
  logic                        wr;

  function automatic logic win_hit(input logic [bmar_pkg::ADDR_W-1:0] a,
                                   input logic [bmar_pkg::ADDR_W-1:0] base,
                                   input logic [bmar_pkg::LIM_W-1:0]  lim);
    logic [bmar_pkg::ADDR_W-1:0] diff;
    diff = a - base;
    return (a >= base) && ({1'b0, diff} < lim);
  endfunction

  // clamp window lengths to the store depth
  assign ram_lim = ({1'b0, ram_length} > bmar_pkg::LIM_W'(bmar_pkg::RAM_DEPTH)) ?
                   bmar_pkg::LIM_W'(bmar_pkg::RAM_DEPTH) : {1'b0, ram_length};
  assign rom_lim = ({1'b0, rom_length} > bmar_pkg::LIM_W'(bmar_pkg::ROM_DEPTH)) ?
                   bmar_pkg::LIM_W'(bmar_pkg::ROM_DEPTH) : {1'b0, rom_length};

  assign ram_off_a = address_reg - ram_base;
  assign rom_off_a = address_reg - rom_base;
  assign ram_off_p = item.preload_address - ram_base;
  assign rom_off_p = item.preload_address - rom_base;

  assign ram_hit_a = win_hit(address_reg, ram_base, ram_lim);
  assign rom_hit_a = win_hit(address_reg, rom_base, rom_lim);
  assign ram_hit_p = win_hit(item.preload_address, ram_base, ram_lim);
  assign rom_hit_p = win_hit(item.preload_address, rom_base, rom_lim);

  assign de = !item.data_enable_n;
  assign ae = !item.address_enable_n;
  assign rd = de && (item.get_id == bmar_pkg::DEV_MEMORY);
  assign wr = de && (item.put_id == bmar_pkg::DEV_MEMORY);

  always_comb begin
    req       = '0;
    req.wdata = item.data_bus_byte;
    if (item.cmd) begin
      // preload: RAM wins where the windows overlap
      req.ram_en   = ram_hit_p;
      req.ram_we   = ram_hit_p;
      req.ram_addr = ram_off_p[bmar_pkg::RAM_AW-1:0];
      req.rom_en   = !ram_hit_p && rom_hit_p;
      req.rom_we   = !ram_hit_p && rom_hit_p;
      req.rom_addr = rom_off_p[bmar_pkg::ROM_AW-1:0];
      req.fault    = !ram_hit_p && !rom_hit_p;
    end else begin
      req.rd_ram   = rd && ram_hit_a;
      req.rd_rom   = rd && !ram_hit_a && rom_hit_a;
      req.ram_en   = (rd || wr) && ram_hit_a;
      req.ram_we   = wr && ram_hit_a;
      req.ram_addr = ram_off_a[bmar_pkg::RAM_AW-1:0];
      req.rom_en   = rd && !ram_hit_a && rom_hit_a;
      req.rom_addr = rom_off_a[bmar_pkg::ROM_AW-1:0];
      req.fault    = (rd && !ram_hit_a && !rom_hit_a) || (wr && !ram_hit_a);
    end
  end

  always_comb begin
    address_reg_next = address_reg;
    if (!item.cmd && !wr && (item.put_id == bmar_pkg::DEV_ADDRESS)) begin
      if (ae) begin
        address_reg_next = {item.addr_bus_byte, item.data_bus_byte};
      end else if (de) begin
        if (item.high_byte_sel) begin
          address_reg_next = (address_reg & bmar_pkg::LOW_BYTE_MASK) |
                             {item.data_bus_byte, 8'h00};
        end else begin
          address_reg_next = (address_reg & bmar_pkg::HIGH_BYTE_MASK) |
                             {8'h00, item.data_bus_byte};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_base    <= bmar_pkg::RAM_BASE_RST;
      ram_length  <= bmar_pkg::RAM_LENGTH_RST;
      rom_base    <= bmar_pkg::ROM_BASE_RST;
      rom_length  <= bmar_pkg::ROM_LENGTH_RST;
      address_reg <= '0;
    end else begin
      if (cfg_we) begin
        unique case (bmar_pkg::cfg_idx_t'(cfg_index))
          bmar_pkg::CFG_RAM_BASE:   ram_base   <= cfg_data;
          bmar_pkg::CFG_RAM_LENGTH: ram_length <= cfg_data;
          bmar_pkg::CFG_ROM_BASE:   rom_base   <= cfg_data;
          bmar_pkg::CFG_ROM_LENGTH: rom_length <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        address_reg <= address_reg_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bus_memory_with_address_register_unit.sv =====
// ----------------------------------------------------------------------------
// bus_memory_with_address_register_unit
// Memory of an 8-bit bus machine: RAM and ROM windows plus address register.
// ----------------------------------------------------------------------------
// After reset the unit sweeps the RAM to zero, one entry per cycle; in_ready
// stays low during the sweep while configuration writes are taken as usual.
// After that one bus transaction is accepted per cycle while the output does
// not stall: the RAM and ROM are addressed at the accepting edge (a read sees
// the entry as it was before a write of the same transaction), and the
// result passes from the memory read register, held with the stage register,
// into the output register. Sustained throughput is one transaction per cycle
// without output stalls, bound by the single port of each memory. A ROM entry
// never preloaded since reset reads as an arbitrary byte.
`default_nettype none

module bus_memory_with_address_register_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire bmar_pkg::in_item_t                  in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output bmar_pkg::out_item_t                      out_data,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [bmar_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [bmar_pkg::ADDR_W-1:0]         cfg_data
);

  typedef enum logic {ST_CLEAR, ST_RUN} state_t;

  typedef struct packed {
    logic rd_ram;
    logic rd_rom;
    logic fault;
  } stage_t;

  state_t                        state;
  logic [bmar_pkg::RAM_AW-1:0]   clr_addr;
  logic                          clearing;
  logic                          accept;
  logic                          s1_valid;
  logic                          s1_adv;
  stage_t                        s1;
  bmar_pkg::mem_req_t            req;

  logic                          ram_en;
  logic                          ram_we;
  logic [bmar_pkg::RAM_AW-1:0]   ram_addr;
  logic [bmar_pkg::BYTE_W-1:0]   ram_wdata;
  logic [bmar_pkg::BYTE_W-1:0]   ram_rdata;
  logic [bmar_pkg::BYTE_W-1:0]   rom_rdata;

  assign clearing  = (state == ST_CLEAR);
  assign cfg_ready = 1'b1;
  assign s1_adv    = !out_valid || out_ready;
  assign in_ready  = (state == ST_RUN) && (!s1_valid || s1_adv);
  assign accept    = in_valid && in_ready;

  bmar_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (in_data),
    .accept    (accept),
    .req       (req)
  );

  // the clearing sweep owns the RAM port until it finishes
  assign ram_en    = clearing || (accept && req.ram_en);
  assign ram_we    = clearing || (accept && req.ram_we);
  assign ram_addr  = clearing ? clr_addr : req.ram_addr;
  assign ram_wdata = clearing ? '0 : req.wdata;

  bmar_ram #(
    .DEPTH (bmar_pkg::RAM_DEPTH),
    .WIDTH (bmar_pkg::BYTE_W),
    .AW    (bmar_pkg::RAM_AW)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  bmar_ram #(
    .DEPTH (bmar_pkg::ROM_DEPTH),
    .WIDTH (bmar_pkg::BYTE_W),
    .AW    (bmar_pkg::ROM_AW)
  ) u_rom (
    .clk   (clk),
    .en    (accept && req.rom_en),
    .we    (accept && req.rom_we),
    .addr  (req.rom_addr),
    .wdata (req.wdata),
    .rdata (rom_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == bmar_pkg::RAM_AW'(bmar_pkg::RAM_DEPTH - 1)) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: ;
        default: state <= ST_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_valid && s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload: hold while the output stalls, memory read data holds with it
  always_ff @(posedge clk) begin
    if (accept) begin
      s1.rd_ram <= req.rd_ram;
      s1.rd_rom <= req.rd_rom;
      s1.fault  <= req.fault;
    end
    if (s1_valid && s1_adv) begin
      out_data.drive_valid <= s1.rd_ram || s1.rd_rom;
      out_data.fault       <= s1.fault;
      if (s1.rd_ram) begin
        out_data.drive_byte <= ram_rdata;
      end else if (s1.rd_rom) begin
        out_data.drive_byte <= rom_rdata;
      end else begin
        out_data.drive_byte <= '0;
      end
    end
  end

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready)
    else $error("transaction accepted during RAM clearing");

  a_single_store_write: assert property (@(posedge clk) disable iff (rst)
    accept |-> !(req.ram_we && req.rom_we))
    else $error("transaction writes RAM and ROM at once");

  a_single_read_source: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !(s1.rd_ram && s1.rd_rom))
    else $error("read selects RAM and ROM at once");

  a_idle_bus_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.drive_valid) |-> (out_data.drive_byte == '0))
    else $error("nonzero byte without bus drive");

  a_stage_moves_out: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_adv && !accept) |=> (out_valid && !s1_valid))
    else $error("transaction lost between stage and output");

endmodule

`default_nettype wire
